@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pfa_pkg.sv @@
package pfa_pkg;

  localparam int FRAME_TOTAL = 1024;
  localparam int IDX_W       = $clog2(FRAME_TOTAL);
  localparam int CNT_W       = $clog2(FRAME_TOTAL + 1);
  localparam int FRAME_SHIFT = 12;

  typedef enum logic [1:0] {
    K_ALLOC_ONE  = 2'd0,
    K_FREE_ONE   = 2'd1,
    K_ALLOC_RUN  = 2'd2,
    K_FREE_RANGE = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

endpackage

@@ rtl/pfa_ram.sv @@
module pfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/page_frame_map_allocator_top.sv @@
// Flow: freeing one frame or a valid range marks its frames free, then gives the
// result; a bad request goes straight to the result; allocating one or a run searches
// the map, marks the frames found (none if the map is full) and then gives the result.
// Throughput: one request at a time; the simple dual-port frame map memory is read
// or written one frame per cycle. Reset: synchronous rst starts a pass that marks
// every frame free; no request is taken until it ends. region_base resets to 0.
`include "assert_macros.svh"

module page_frame_map_allocator_top
  import pfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] frame_address,
  input  logic [10:0] frame_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_address,
  output logic [1:0]  status
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_FIN} state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_TOTAL - 1);

  state_t            state;
  logic [31:0]       region_base;
  logic [IDX_W-1:0]  mark_idx;
  logic [IDX_W-1:0]  mark_end;
  logic              mark_val;
  logic [CNT_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  chk_idx;
  logic              chk_vld;
  logic [CNT_W-1:0]  run;
  logic [10:0]       target;
  logic [IDX_W-1:0]  res_start;
  logic              res_has_addr;
  logic [1:0]        res_stat;

  logic              ram_wr_en;
  logic              ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic              ram_rd_data;

  logic [31:0]       off;
  logic [IDX_W-1:0]  a_idx;
  logic              addr_ok;
  logic              cnt_ok;
  logic              range_ok;
  logic [31:0]       range_last;
  logic [CNT_W-1:0]  run_inc;
  logic              hit;
  logic [31:0]       start_calc;
  logic [31:0]       start_ofs;

  assign in_stall = (state != S_IDLE);

  // Request decode: offset from the region base, checked for alignment and range.
  assign off        = frame_address - region_base;
  assign a_idx      = off[IDX_W+FRAME_SHIFT-1:FRAME_SHIFT];
  assign addr_ok    = (off[FRAME_SHIFT-1:0] == '0) &&
                      ({12'd0, off[31:FRAME_SHIFT]} < 32'(FRAME_TOTAL));
  assign cnt_ok     = (frame_count != '0) && ({21'd0, frame_count} <= 32'(FRAME_TOTAL));
  assign range_ok   = ({12'd0, off[31:FRAME_SHIFT]} + {21'd0, frame_count})
                      <= 32'(FRAME_TOTAL);
  assign range_last = {{(32-IDX_W){1'b0}}, a_idx} + {21'd0, frame_count} - 32'd1;

  // Search step on the frame mark returned by the memory.
  assign run_inc    = run + CNT_W'(1);
  assign hit        = chk_vld && !ram_rd_data &&
                      ({{(32-CNT_W){1'b0}}, run_inc} == {21'd0, target});
  assign start_calc = {{(32-IDX_W){1'b0}}, chk_idx} + 32'd1 - {21'd0, target};
  assign start_ofs  = {{(32-IDX_W-FRAME_SHIFT){1'b0}}, res_start, {FRAME_SHIFT{1'b0}}};

  assign ram_rd_en   = (state == S_SCAN) &&
                       ({{(32-CNT_W){1'b0}}, scan_idx} < 32'(FRAME_TOTAL));
  assign ram_rd_addr = scan_idx[IDX_W-1:0];
  assign ram_wr_en   = (state == S_CLEAR) || (state == S_MARK);
  assign ram_wr_data = (state == S_MARK) && mark_val;

  pfa_ram #(
    .WIDTH (1),
    .DEPTH (FRAME_TOTAL)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (mark_idx),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      mark_idx    <= '0;
      out_valid   <= 1'b0;
      region_base <= '0;
      chk_vld     <= 1'b0;
    end else begin
      if (cfg_write) begin
        region_base <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      chk_vld <= ram_rd_en;
      chk_idx <= ram_rd_addr;

      unique case (state)
        S_CLEAR: begin
          mark_idx <= mark_idx + IDX_W'(1);
          if (mark_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            res_has_addr <= 1'b0;
            run          <= '0;
            scan_idx     <= '0;
            unique case (kind_t'(kind))
              K_ALLOC_ONE: begin
                target <= 11'd1;
                state  <= S_SCAN;
              end
              K_ALLOC_RUN: begin
                target <= frame_count;
                if (cnt_ok) begin
                  state <= S_SCAN;
                end else begin
                  res_stat <= ST_BAD;
                  state    <= S_FIN;
                end
              end
              K_FREE_ONE: begin
                mark_idx <= a_idx;
                mark_end <= a_idx;
                mark_val <= 1'b0;
                if (addr_ok) begin
                  res_stat <= ST_OK;
                  state    <= S_MARK;
                end else begin
                  res_stat <= ST_BAD;
                  state    <= S_FIN;
                end
              end
              K_FREE_RANGE: begin
                mark_idx <= a_idx;
                mark_end <= range_last[IDX_W-1:0];
                mark_val <= 1'b0;
                if (cnt_ok && addr_ok && range_ok) begin
                  res_stat <= ST_OK;
                  state    <= S_MARK;
                end else begin
                  res_stat <= ST_BAD;
                  state    <= S_FIN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (ram_rd_en) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (chk_vld) begin
            run <= ram_rd_data ? '0 : run_inc;
            if (hit) begin
              mark_idx     <= start_calc[IDX_W-1:0];
              mark_end     <= chk_idx;
              mark_val     <= 1'b1;
              res_start    <= start_calc[IDX_W-1:0];
              res_has_addr <= 1'b1;
              res_stat     <= ST_OK;
              state        <= S_MARK;
            end else if (chk_idx == LAST_IDX) begin
              res_stat <= ST_FULL;
              state    <= S_FIN;
            end
          end
        end
        S_MARK: begin
          mark_idx <= mark_idx + IDX_W'(1);
          if (mark_idx == mark_end) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            result_address <= res_has_addr ? (region_base + start_ofs) : 32'd0;
            status         <= res_stat;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PFA_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept while busy")
  `PFA_ASSERT_NOW(a_write_phase, ram_wr_en, state == S_CLEAR || state == S_MARK, "stray write")
  `PFA_ASSERT_NOW(a_fail_zero_addr, out_valid && status != ST_OK, result_address == '0, "addr set")

endmodule

@@ tb/sv/page_frame_map_allocator_top_test.sv @@
`timescale 1ns / 100ps

module page_frame_map_allocator_top_test;
  import pfa_pkg::*;

  localparam int unsigned WATCH_LIMIT = 12000;
  localparam int unsigned PHASE_ITEMS = 111;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned BUSY_FRAMES = 300;
  localparam logic [31:0] PAGE_BYTES = 32'h1000;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  st;
  } grant_t;

  typedef struct {
    int unsigned first;
    int unsigned cnt;
  } block_t;

  class frame_map_scoreboard;
    bit [FRAME_TOTAL-1:0] used;
    logic [31:0] base;
    grant_t grant_q[$];
    int unsigned mismatches;

    function new();
      used = '0;
      base = '0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return grant_q.size();
    endfunction

    function bit frame_index(input logic [31:0] addr, output int unsigned idx);
      logic [31:0] off;
      off = addr - base;
      idx = 0;
      if (off[FRAME_SHIFT-1:0] != '0) return 0;
      off = off >> FRAME_SHIFT;
      if (off >= FRAME_TOTAL) return 0;
      idx = off;
      return 1;
    endfunction

    // Apply one request to the frame map and queue the answer it must produce.
    function grant_t note_request(input kind_t k, input logic [31:0] addr,
                                  input logic [10:0] cnt);
      grant_t g;
      int unsigned idx;
      int unsigned run;
      bit hit;
      g.addr = '0;
      g.st = ST_OK;
      case (k)
        K_ALLOC_ONE: begin
          g.st = ST_FULL;
          for (int i = 0; i < FRAME_TOTAL; i++) begin
            if (!used[i]) begin
              used[i] = 1'b1;
              g.addr = base + PAGE_BYTES * i;
              g.st = ST_OK;
              break;
            end
          end
        end
        K_FREE_ONE: begin
          if (frame_index(addr, idx)) used[idx] = 1'b0;
          else g.st = ST_BAD;
        end
        K_ALLOC_RUN: begin
          if (cnt == 0 || cnt > FRAME_TOTAL) begin
            g.st = ST_BAD;
          end else begin
            g.st = ST_FULL;
            run = 0;
            for (int i = 0; i < FRAME_TOTAL; i++) begin
              if (used[i]) begin
                run = 0;
              end else begin
                run++;
                if (run == cnt) begin
                  idx = i + 1 - cnt;
                  for (int j = idx; j < idx + cnt; j++) used[j] = 1'b1;
                  g.addr = base + PAGE_BYTES * idx;
                  g.st = ST_OK;
                  break;
                end
              end
            end
          end
        end
        default: begin
          hit = frame_index(addr, idx);
          if (cnt == 0 || cnt > FRAME_TOTAL || !hit || idx + cnt > FRAME_TOTAL) begin
            g.st = ST_BAD;
          end else begin
            for (int j = idx; j < idx + cnt; j++) used[j] = 1'b0;
          end
        end
      endcase
      grant_q.push_back(g);
      return g;
    endfunction

    function void check_result(input logic [31:0] addr, input logic [1:0] st);
      grant_t g;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: address %h status %0d", addr, st);
        return;
      end
      g = grant_q.pop_front();
      if (addr !== g.addr || st !== g.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected address %h status %0d, got address %h status %0d",
                   g.addr, g.st, addr, st);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = K_ALLOC_ONE;
  logic [31:0] frame_address = '0;
  logic [10:0] frame_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_address;
  logic [1:0]  status;

  frame_map_scoreboard sb = new();
  block_t held_q[$];
  bit idle_on;
  bit stall_on;
  bit long_hold_req;
  int unsigned stall_left;

  page_frame_map_allocator_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .frame_address(frame_address),
    .frame_count(frame_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_address(result_address),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_request(input kind_t k, input logic [31:0] a, input logic [10:0] c);
    grant_t g;
    block_t b;
    in_valid <= 1'b1;
    kind <= k;
    frame_address <= a;
    frame_count <= c;
    do @(posedge clk); while (in_stall);
    g = sb.note_request(k, a, c);
    // Track every granted block so later requests can hand it back.
    if (g.st == ST_OK && (k == K_ALLOC_ONE || k == K_ALLOC_RUN)) begin
      b.first = (g.addr - sb.base) >> FRAME_SHIFT;
      b.cnt = (k == K_ALLOC_ONE) ? 1 : c;
      held_q.push_back(b);
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic free_block();
    int unsigned pick;
    block_t b;
    logic [31:0] a;
    pick = $urandom_range(0, held_q.size() - 1);
    b = held_q[pick];
    held_q.delete(pick);
    a = sb.base + PAGE_BYTES * b.first;
    if (b.cnt == 1 && $urandom_range(0, 1) == 1)
      send_request(K_FREE_ONE, a, 11'($urandom_range(0, 2047)));
    else
      send_request(K_FREE_RANGE, a, 11'(b.cnt));
  endtask

  task automatic noise_request();
    kind_t k;
    logic [31:0] a;
    logic [10:0] c;
    k = kind_t'($urandom_range(0, 3));
    c = 11'($urandom_range(0, 2047));
    case ($urandom_range(0, 3))
      0: a = $urandom;
      1: a = sb.base + PAGE_BYTES * $urandom_range(0, FRAME_TOTAL - 1) + $urandom_range(1, 4095);
      2: a = sb.base + PAGE_BYTES * $urandom_range(FRAME_TOTAL, 4095);
      default: begin
        a = sb.base + PAGE_BYTES * $urandom_range(0, FRAME_TOTAL - 1);
        c = 11'($urandom_range(1, 64));
      end
    endcase
    send_request(k, a, c);
  endtask

  task automatic random_request();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    // Drain the map when it gets crowded so searches stay short.
    if ($countones(sb.used) > BUSY_FRAMES && held_q.size() != 0) roll = 60;
    if (roll < 30)
      send_request(K_ALLOC_ONE, $urandom, 11'($urandom_range(0, 2047)));
    else if (roll < 55)
      send_request(K_ALLOC_RUN, $urandom,
                   11'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                   : $urandom_range(1, 8)));
    else if (roll < 85 && held_q.size() != 0)
      free_block();
    else
      noise_request();
  endtask

  task automatic set_region_base(input logic [31:0] b);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.base = b;
  endtask

  // Result side: check accepted results and stall in random bursts.
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) sb.check_result(result_address, status);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && stall_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCH_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [31:0] phase_base [4];
    idle_on = 1'b1;
    stall_on = 1'b1;
    long_hold_req = 1'b0;
    phase_base[0] = 32'hFFFF_FFFF;
    phase_base[1] = 32'hFFE0_0000;
    phase_base[2] = $urandom;
    phase_base[3] = $urandom & 32'hFFFF_F000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_region_base(32'h0000_0000);

    send_request(K_ALLOC_ONE, 32'hFFFF_FFFF, 11'h7FF);
    send_request(K_ALLOC_ONE, 32'h0, 11'h0);
    send_request(K_FREE_ONE, 32'h0000_0000, 11'h0);
    // freeing a frame that is already free is fine
    send_request(K_FREE_ONE, 32'h0000_0000, 11'h7FF);
    send_request(K_FREE_ONE, 32'h0000_0001, 11'd1);
    send_request(K_FREE_ONE, 32'h0040_0000, 11'd1);
    send_request(K_FREE_ONE, 32'hFFFF_F000, 11'd1);
    send_request(K_ALLOC_RUN, 32'h0, 11'd0);
    send_request(K_ALLOC_RUN, 32'h0, 11'd1025);
    send_request(K_ALLOC_RUN, 32'h0, 11'h7FF);
    // frame 1 is held, so no run this long fits
    send_request(K_ALLOC_RUN, 32'h0, 11'd1023);
    send_request(K_ALLOC_RUN, 32'h0, 11'd1024);
    send_request(K_FREE_RANGE, 32'h0000_1000, 11'd1023);
    send_request(K_FREE_RANGE, 32'h0000_2000, 11'd1023);
    send_request(K_FREE_RANGE, 32'h0000_1000, 11'd0);
    send_request(K_FREE_RANGE, 32'h0000_0000, 11'd1025);
    send_request(K_FREE_RANGE, 32'h0000_0800, 11'd1);
    send_request(K_ALLOC_RUN, 32'h0, 11'd1024);
    send_request(K_ALLOC_ONE, 32'h0, 11'd0);
    send_request(K_ALLOC_RUN, 32'h0, 11'd1);
    send_request(K_FREE_ONE, 32'h003F_F000, 11'd0);
    send_request(K_ALLOC_RUN, 32'h0, 11'd2);
    send_request(K_ALLOC_ONE, 32'h0, 11'd0);
    send_request(K_FREE_RANGE, 32'h0000_0000, 11'd1024);
    // the map is empty again
    held_q.delete();

    for (int n = 0; n < PHASE_ITEMS; n++) random_request();

    for (int p = 0; p < 4; p++) begin
      if (p == 3) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end
      set_region_base(phase_base[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 40) long_hold_req = 1'b1;
        if (p == 1 && n == 50) begin
          // hold off until every request has been answered
          in_valid <= 1'b0;
          while (sb.outstanding() != 0) @(posedge clk);
        end
        random_request();
      end
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
